[hdl/cdnc_pkg.sv]
package cdnc_pkg;

  // Last calendar year the converter covers.
  localparam int unsigned LAST_YEAR = 65535;

  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 25;
  localparam int unsigned DATA_W  = 56;

  // Calendar anchors (absolute day numbers, day 0 = 1 Jan of year 0)
  localparam logic [COUNT_W-1:0] JUL_LAST   = 25'd578102; // 4 Oct 1582
  localparam logic [COUNT_W-1:0] GREG_BASE  = 25'd578180; // 31 Dec 1582
  localparam logic [COUNT_W-1:0] GREG_FIRST = 25'd578181; // 1 Jan 1583
  localparam logic [YEAR_W-1:0]  SHIFT_YEAR = 16'd1582;
  localparam logic [YEAR_W-1:0]  GREG_YEAR  = 16'd1583;

  // x / 1461 == (x * DIV1461_M) >> DIV1461_SH, exact for x < 2**27
  localparam int unsigned DIV1461_SH = 38;
  localparam logic [27:0] DIV1461_M =
    28'(((64'd1 << DIV1461_SH) + 64'd1460) / 64'd1461);
  // y / 25 == (y * DIV25_M) >> DIV25_SH, exact for y < 2**14
  localparam int unsigned DIV25_SH = 17;
  localparam logic [12:0] DIV25_M = 13'd5243;

  typedef enum logic [1:0] {
    RGN_JULIAN = 2'd0,
    RGN_SHIFT  = 2'd1,
    RGN_GREG   = 2'd2,
    RGN_OOR    = 2'd3
  } region_e;

  typedef struct packed {
    logic load_in;
    logic div;
    logic est;
    logic oor;
    logic ydiv;
    logic base;
    logic take;
    logic next;
    logic fwd;
    logic split;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic    cmd;
    region_e region;
    logic    base_le_cnt;
    logic    at_last;
  } dp_sts_t;

  // Day number of 31 December of a Gregorian year (elaboration only)
  function automatic logic [COUNT_W-1:0] dec31_day(int unsigned y);
    int unsigned ym1;
    int unsigned leap;
    int unsigned days;
    ym1  = y - 1;
    leap = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 1 : 0;
    days = 365 * y + ym1 / 4 - ym1 / 100 + ym1 / 400 + 3 + 364 + leap;
    return days[COUNT_W-1:0];
  endfunction

  localparam logic [COUNT_W-1:0] LAST_DAY = dec31_day(LAST_YEAR);

endpackage

[hdl/calendar_day_number_converter.sv]
// Calendar date <-> absolute day number converter (day 0 = 1 January, year 0).
// Input stream: s_axis_tuser selects the conversion (0: date to day number,
// 1: day number to date); s_axis_tdata carries year, month, day, day_count.
// Output stream: one item per input item; day_number for a date, or
// year/month/day for a day number, zeros elsewhere; m_axis_tuser flags a day
// number past 31 December of the last year.
// A date, or a day number up to 1582, goes once through the year unit's
// multiply stages; a later day number may take further passes. The year is
// estimated with one reciprocal multiply and then advanced one year per pass
// through the year unit (two multiply stages and a compare). One item is in
// work at a time; the block is ready for the next item once the result moves
// into the output register.
// Reset clears the controller and empties the output register.
// A stalled receiver holds the result in the output register; the block
// still accepts and works on one more item, then waits with its result.
module calendar_day_number_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // year[15:0] month[19:16] day[24:20] day_count[49:25]
  input  logic        s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // day_number[24:0] out_year[40:25] out_month[44:41]
                                     // out_day[49:45]
  output logic        m_axis_tuser   // out_of_range
);

  cdnc_pkg::dp_cmd_t dp_cmd;
  cdnc_pkg::dp_sts_t dp_sts;

  cdnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  cdnc_dp u_dp (
    .clk_i       (clk_i),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

endmodule

[hdl/cdnc_dp.sv]
module cdnc_dp (
  input  logic                     clk_i,
  input  logic [55:0]              in_tdata_i,
  input  logic                     in_tuser_i,
  input  cdnc_pkg::dp_cmd_t        cmd_i,
  output cdnc_pkg::dp_sts_t        sts_o,
  output logic [55:0]              out_tdata_o,
  output logic                     out_tuser_o
);

  localparam logic [8:0] MonthStart [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  // returns {month, day} for a day offset inside a year
  function automatic logic [8:0] split_md(logic [8:0] rem, logic leap);
    logic [8:0] r2;
    logic [3:0] m;
    logic [4:0] g;
    r2 = rem - 9'(leap);
    m  = 4'd12;
    for (int k = 11; k >= 3; k--) begin
      if (r2 < MonthStart[4'(k)]) m = 4'(k);
    end
    g = 5'(r2 - MonthStart[m - 4'd1] + 9'd1);
    if (rem < 9'd31) begin
      m = 4'd1;
      g = 5'(rem + 9'd1);
    end else if (rem < 9'd59) begin
      m = 4'd2;
      g = 5'(rem - 9'd30);
    end else if (r2 == 9'd58) begin
      m = 4'd2;
      g = 5'd29;
    end
    return {m, g};
  endfunction

  logic                   cmd_q;
  logic [15:0]            ywork_q, ywork_d;
  logic [3:0]             mon_q, mon_d;
  logic [4:0]             day_q, day_d;
  logic [24:0]            cnt_q;
  cdnc_pkg::region_e      region_q, region_d;
  logic [15:0]            qd_q, qd_d;
  logic [9:0]             q100_q, q100_d;
  logic [24:0]            m365_q, m365_d;
  logic [24:0]            base_q, base_d;
  logic                   leap_q, leap_d;
  logic [15:0]            yacc_q;
  logic [24:0]            jacc_q;
  logic                   lacc_q;
  logic [55:0]            res_data_q, res_data_d;
  logic                   res_oor_q, res_oor_d;
  logic [55:0]            out_data_q;
  logic                   out_oor_q;

  // input unpacking with month/day clamping
  always_comb begin
    mon_d = in_tdata_i[19:16];
    if (mon_d == 4'd0) mon_d = 4'd1;
    if (mon_d > 4'd12) mon_d = 4'd12;
    day_d = in_tdata_i[24:20];
    if (day_d == 5'd0) day_d = 5'd1;
  end

  // region of the day count and year estimate by a reciprocal multiply
  logic [24:0] div_src;
  logic [54:0] div_prod;
  always_comb begin
    if (cnt_q > cdnc_pkg::LAST_DAY) begin
      region_d = cdnc_pkg::RGN_OOR;
    end else if (cnt_q <= cdnc_pkg::JUL_LAST) begin
      region_d = cdnc_pkg::RGN_JULIAN;
    end else if (cnt_q <= cdnc_pkg::GREG_BASE) begin
      region_d = cdnc_pkg::RGN_SHIFT;
    end else begin
      region_d = cdnc_pkg::RGN_GREG;
    end
    div_src  = (cnt_q <= cdnc_pkg::JUL_LAST) ? cnt_q : cnt_q - cdnc_pkg::GREG_FIRST;
    div_prod = 55'({div_src, 2'b00}) * 55'(cdnc_pkg::DIV1461_M);
    qd_d     = div_prod[cdnc_pkg::DIV1461_SH +: 16];
  end

  // starting year for the day-count conversion
  logic [15:0] est_year;
  always_comb begin
    case (region_q)
      cdnc_pkg::RGN_JULIAN: est_year = qd_q;
      cdnc_pkg::RGN_SHIFT:  est_year = cdnc_pkg::SHIFT_YEAR;
      default: begin
        // two years below the 365.25-day estimate never overshoots
        est_year = cdnc_pkg::GREG_YEAR + ((qd_q >= 16'd2) ? qd_q - 16'd2 : 16'd0);
      end
    endcase
  end

  // year unit, stage 1: year / 100 and 365 * year
  logic [26:0] q100_prod;
  always_comb begin
    q100_prod = 27'(ywork_q[15:2]) * 27'(cdnc_pkg::DIV25_M);
    q100_d    = q100_prod[cdnc_pkg::DIV25_SH +: 10];
    m365_d    = 25'(25'(ywork_q) * 25'd365);
  end

  // year unit, stage 2: day number of 1 January and leap flag
  logic [16:0] hund;
  logic [6:0]  r100;
  logic [9:0]  q1;
  logic [24:0] greg_base, jul_base;
  logic        greg_leap;
  always_comb begin
    hund      = 17'(q100_q) * 17'd100;
    r100      = 7'(17'(ywork_q) - hund);
    q1        = q100_q - 10'(r100 == 7'd0);   // (year - 1) / 100
    greg_base = m365_q + 25'((ywork_q - 16'd1) >> 2) - 25'(q1) + 25'(q1 >> 2) + 25'd3;
    jul_base  = m365_q + 25'((17'(ywork_q) + 17'd3) >> 2);
    greg_leap = (ywork_q[1:0] == 2'd0) && ((r100 != 7'd0) || (q100_q[1:0] == 2'd0));
    if (ywork_q <= cdnc_pkg::SHIFT_YEAR) begin
      base_d = jul_base;
      leap_d = (ywork_q[1:0] == 2'd0);
    end else begin
      base_d = greg_base;
      leap_d = greg_leap;
    end
  end

  // date to day number
  logic        early, shifted, leap_inc;
  logic [25:0] dn_sum;
  // day number to date
  logic [24:0] rem_full;
  logic [8:0]  md;
  always_comb begin
    early    = (ywork_q < cdnc_pkg::SHIFT_YEAR) ||
               ((ywork_q == cdnc_pkg::SHIFT_YEAR) &&
                ((mon_q < 4'd10) || ((mon_q == 4'd10) && (day_q < 5'd5))));
    shifted  = (ywork_q == cdnc_pkg::SHIFT_YEAR) && !early;
    leap_inc = (mon_q > 4'd2) && leap_q && !shifted;
    dn_sum   = 26'(base_q) + 26'(day_q) + 26'(MonthStart[mon_q - 4'd1]) + 26'(leap_inc)
               - 26'd1 - (shifted ? 26'd10 : 26'd0);

    rem_full = cnt_q - jacc_q + ((region_q == cdnc_pkg::RGN_SHIFT) ? 25'd10 : 25'd0);
    md       = split_md(rem_full[8:0], lacc_q);

    res_data_d = res_data_q;
    res_oor_d  = res_oor_q;
    if (cmd_i.fwd) begin
      res_data_d = {31'd0, dn_sum[24:0]};
      res_oor_d  = (32'(ywork_q) > cdnc_pkg::LAST_YEAR);
    end else if (cmd_i.split) begin
      res_data_d = {6'd0, md[4:0], md[8:5], yacc_q, 25'd0};
      res_oor_d  = 1'b0;
    end else if (cmd_i.oor) begin
      res_data_d = '0;
      res_oor_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= in_tuser_i;
      ywork_q <= in_tdata_i[15:0];
      mon_q   <= mon_d;
      day_q   <= day_d;
      cnt_q   <= in_tdata_i[49:25];
    end else if (cmd_i.est) begin
      ywork_q <= est_year;
    end else if (cmd_i.next) begin
      ywork_q <= yacc_q + 16'd1;
    end
    if (cmd_i.div) begin
      region_q <= region_d;
      qd_q     <= qd_d;
    end
    if (cmd_i.ydiv) begin
      q100_q <= q100_d;
      m365_q <= m365_d;
    end
    if (cmd_i.base) begin
      base_q <= base_d;
      leap_q <= leap_d;
    end
    if (cmd_i.take) begin
      yacc_q <= ywork_q;
      jacc_q <= base_q;
      lacc_q <= leap_q;
    end
    res_data_q <= res_data_d;
    res_oor_q  <= res_oor_d;
    if (cmd_i.load_out) begin
      out_data_q <= res_data_q;
      out_oor_q  <= res_oor_q;
    end
  end

  assign sts_o.cmd         = cmd_q;
  assign sts_o.region      = region_q;
  assign sts_o.base_le_cnt = (base_q <= cnt_q);
  assign sts_o.at_last     = (32'(yacc_q) >= cdnc_pkg::LAST_YEAR);

  assign out_tdata_o = out_data_q;
  assign out_tuser_o = out_oor_q;

endmodule

[hdl/cdnc_ctrl.sv]
module cdnc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  cdnc_pkg::dp_sts_t   sts_i,
  output cdnc_pkg::dp_cmd_t   cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_DIV   = 10'b00_0000_0010,
    ST_EST   = 10'b00_0000_0100,
    ST_YDIV  = 10'b00_0000_1000,
    ST_BASE  = 10'b00_0001_0000,
    ST_FWD   = 10'b00_0010_0000,
    ST_TEST  = 10'b00_0100_0000,
    ST_STEP  = 10'b00_1000_0000,
    ST_SPLIT = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_EST;
      end
      ST_EST: begin
        if (!sts_i.cmd) begin
          state_d = ST_YDIV;
        end else if (sts_i.region == cdnc_pkg::RGN_OOR) begin
          cmd_o.oor = 1'b1;
          state_d   = ST_DONE;
        end else begin
          cmd_o.est = 1'b1;
          state_d   = ST_YDIV;
        end
      end
      ST_YDIV: begin
        cmd_o.ydiv = 1'b1;
        state_d    = ST_BASE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = sts_i.cmd ? ST_TEST : ST_FWD;
      end
      ST_FWD: begin
        cmd_o.fwd = 1'b1;
        state_d   = ST_DONE;
      end
      ST_TEST: begin
        // keep the candidate year while its 1 January is not past the count
        if (sts_i.base_le_cnt) begin
          cmd_o.take = 1'b1;
          state_d    = (sts_i.region == cdnc_pkg::RGN_GREG) ? ST_STEP : ST_SPLIT;
        end else begin
          state_d = ST_SPLIT;
        end
      end
      ST_STEP: begin
        if (sts_i.at_last) begin
          state_d = ST_SPLIT;
        end else begin
          cmd_o.next = 1'b1;
          state_d    = ST_YDIV;
        end
      end
      ST_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

endmodule

[hdl/cdnc_checker.sv]
module cdnc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
      $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  a_oor_no_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[49:25] == 25'd0)
    else $error("date fields set on an out-of-range item");

  a_month_day_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[44:41] == 4'd0) == (m_axis_tdata[49:45] == 5'd0)) &&
      (m_axis_tdata[44:41] <= 4'd12))
    else $error("inconsistent month and day");

endmodule

bind calendar_day_number_converter cdnc_checker u_cdnc_checker (.*);

[bench/tb_top.sv]
module tb_top;
  import cdnc_pkg::*;

  localparam logic CMD_TO_DAYS = 1'b0;
  localparam logic CMD_TO_DATE = 1'b1;

  localparam int unsigned N_RANDOM    = 750;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic                drain;  // hold this item until every result is back
    logic [1:0]          phase;
    logic                cmd;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [COUNT_W-1:0]  day_count;
  } conv_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  day_number;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic                out_of_range;
  } conv_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;

  conv_req_t   req_q[$];
  conv_res_t   conv_exp_q[$];
  logic [1:0]  cur_phase = 2'd0;
  int unsigned n_sent = 0;
  int unsigned n_done = 0;
  int unsigned n_err = 0;
  int unsigned n_dates = 0;
  int unsigned n_counts = 0;
  int unsigned n_oor = 0;
  int unsigned cycle_cnt = 0;

  calendar_day_number_converter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- calendar math

  function automatic int unsigned month_ofs(int unsigned k);
    case (k)
      0:       return 0;
      1:       return 31;
      2:       return 59;
      3:       return 90;
      4:       return 120;
      5:       return 151;
      6:       return 181;
      7:       return 212;
      8:       return 243;
      9:       return 273;
      10:      return 304;
      11:      return 334;
      default: return 365;
    endcase
  endfunction

  // multiples of n in [from, upto)
  function automatic int unsigned multiples_below(int unsigned upto, int unsigned from,
                                                  int unsigned n);
    int unsigned f;
    f = from;
    if (f % n != 0) f = f + n - (f % n);
    return (f >= upto) ? 0 : 1 + (upto - 1 - f) / n;
  endfunction

  function automatic int unsigned greg_leap(int unsigned a);
    return ((a % 4 == 0) && ((a % 100 != 0) || (a % 400 == 0))) ? 1 : 0;
  endfunction

  function automatic int unsigned day_index(int unsigned g, int unsigned m, int unsigned a);
    int unsigned ofs;
    int unsigned leap;
    ofs = month_ofs(m - 1);
    if (a < 1582 || (a == 1582 && (m < 10 || (m == 10 && g < 5)))) begin
      leap = (m > 2 && a % 4 == 0) ? 1 : 0;
      return g - 1 + ofs + leap + 365 * a + multiples_below(a, 0, 4);
    end
    // the ten lost days of October 1582
    if (a == 1582) return g + ofs + 365 * a + multiples_below(a, 0, 4) - 11;
    leap = (m > 2) ? greg_leap(a) : 0;
    return GREG_BASE + g + ofs + leap + 365 * (a - 1583)
         + multiples_below(a, 1582, 4) - multiples_below(a, 1582, 100)
         + multiples_below(a, 1582, 400);
  endfunction

  function automatic void split_rem(input int unsigned rem_in, input int unsigned leap,
                                    output int unsigned mon, output int unsigned dom);
    int unsigned rem;
    int unsigned k;
    rem = rem_in;
    if (rem < 31) begin
      dom = rem + 1;
      mon = 1;
    end else if (rem < 59) begin
      dom = rem - 30;
      mon = 2;
    end else begin
      rem = rem - leap;
      if (rem == 58) begin
        dom = 29;
        mon = 2;
      end else begin
        k = 3;
        while (k < 12 && rem >= month_ofs(k)) k++;
        mon = k;
        dom = rem - month_ofs(k - 1) + 1;
      end
    end
  endfunction

  function automatic conv_res_t convert_item(logic cmd, logic [YEAR_W-1:0] yr,
                                             logic [MONTH_W-1:0] mo, logic [DAY_W-1:0] dy,
                                             logic [COUNT_W-1:0] cnt);
    conv_res_t   r;
    int unsigned y, mm, dd, d, a, m, g, rem, k, last, dn;
    r = '0;
    a = 0;
    m = 0;
    g = 0;
    last = day_index(31, 12, LAST_YEAR);
    if (cmd == CMD_TO_DAYS) begin
      y  = yr;
      mm = mo;
      dd = dy;
      if (mm == 0) mm = 1;
      if (mm > 12) mm = 12;
      if (dd == 0) dd = 1;
      dn = day_index(dd, mm, y);
      r.day_number   = dn[COUNT_W-1:0];
      r.out_of_range = (y > LAST_YEAR);
    end else begin
      d = cnt;
      if (d > last) begin
        r.out_of_range = 1'b1;
      end else if (d <= JUL_LAST) begin
        a = (d * 4) / 1461;
        split_rem(d - day_index(1, 1, a), (a % 4 == 0) ? 1 : 0, m, g);
      end else if (d <= GREG_BASE) begin
        a   = 1582;
        rem = d - day_index(1, 1, a) + 10;
        k   = 10;
        while (k < 12 && rem >= month_ofs(k)) k++;
        m = k;
        g = rem - month_ofs(k - 1) + 1;
      end else begin
        a = 1583 + (d - GREG_FIRST) / 366;
        while (a < LAST_YEAR && day_index(1, 1, a + 1) <= d) a++;
        split_rem(d - day_index(1, 1, a), greg_leap(a), m, g);
      end
    end
    r.out_year  = a[YEAR_W-1:0];
    r.out_month = m[MONTH_W-1:0];
    r.out_day   = g[DAY_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic conv_req_t make_req(logic cmd, int unsigned y, int unsigned mo,
                                         int unsigned dy, int unsigned cnt);
    conv_req_t q;
    q.drain     = 1'b0;
    q.phase     = 2'd0;
    q.cmd       = cmd;
    q.year      = y[YEAR_W-1:0];
    q.month     = mo[MONTH_W-1:0];
    q.day       = dy[DAY_W-1:0];
    q.day_count = cnt[COUNT_W-1:0];
    return q;
  endfunction

  function automatic conv_req_t random_req(logic [1:0] phase);
    conv_req_t   q;
    int unsigned sel;
    int unsigned y;
    q = make_req($urandom_range(1), $urandom, $urandom, $urandom, $urandom);
    q.phase = phase;
    sel = $urandom_range(9);
    if (q.cmd == CMD_TO_DAYS) begin
      case (sel)
        0, 1, 2: q.year = $urandom;
        3, 4: begin
          q.year = $urandom_range(1584, 1580);
          if ($urandom_range(1)) q.month = 10;
        end
        5, 6:    q.year = $urandom_range(1600, 0);
        default: q.year = $urandom_range(2400, 1583);
      endcase
      if (!(sel inside {3, 4}) || q.month != 10)
        q.month = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
      q.day = ($urandom_range(9) == 0) ? 0 : $urandom_range(31, 1);
    end else begin
      case (sel)
        0: q.day_count = $urandom_range(JUL_LAST, 0);
        1: q.day_count = $urandom_range(GREG_FIRST + 40, JUL_LAST - 40);
        2, 3: q.day_count = $urandom_range(LAST_DAY, GREG_FIRST);
        4, 5: begin
          y = $urandom_range(LAST_YEAR, 1584);
          q.day_count = day_index(1, 1, y) + $urandom_range(2) - 1;
        end
        6: begin
          y = $urandom_range(1581, 1);
          q.day_count = day_index(1, 1, y) + $urandom_range(2) - 1;
        end
        7: q.day_count = $urandom_range(LAST_DAY + 400, LAST_DAY - 400);
        8: q.day_count = $urandom;
        default: q.day_count = $urandom_range(LAST_DAY, 0);
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin : drv_proc
    logic        busy;
    int unsigned idle_pct;
    conv_req_t   hd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        n_sent++;
        busy = 1'b0;
      end
      if (!busy && req_q.size() != 0) begin
        hd = req_q[0];
        idle_pct = (hd.phase == 2'd0) ? 11 : (hd.phase == 2'd1) ? 50 : 0;
        if ((!hd.drain || n_done == n_sent) && $urandom_range(99) >= idle_pct) begin
          void'(req_q.pop_front());
          s_axis_tdata <= {6'b0, hd.day_count, hd.day, hd.month, hd.year};
          s_axis_tuser <= hd.cmd;
          cur_phase    <= hd.phase;
          busy = 1'b1;
        end
      end
      s_axis_tvalid <= busy;
    end
  end

  always @(posedge clk_i) begin : rdy_proc
    int unsigned idle_pct;
    idle_pct = (cur_phase == 2'd0) ? 50 : (cur_phase == 2'd1) ? 11 : 0;
    if (!rst_ni) m_axis_tready <= 1'b0;
    else         m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin : mon_proc
    conv_res_t e;
    conv_res_t p;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_done++;
        if (conv_exp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got tdata=%h tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
          n_err++;
        end else begin
          e = conv_exp_q.pop_front();
          check_field("day_number",   e.day_number,   m_axis_tdata[24:0]);
          check_field("out_year",     e.out_year,     m_axis_tdata[40:25]);
          check_field("out_month",    e.out_month,    m_axis_tdata[44:41]);
          check_field("out_day",      e.out_day,      m_axis_tdata[49:45]);
          check_field("out_of_range", e.out_of_range, m_axis_tuser);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        p = convert_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[19:16],
                         s_axis_tdata[24:20], s_axis_tdata[49:25]);
        conv_exp_q.push_back(p);
        if (s_axis_tuser == CMD_TO_DAYS) n_dates++;
        else                             n_counts++;
        if (p.out_of_range) n_oor++;
      end
    end
  end

  // ---------------------------------------------------------------- run control

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, conv_exp_q.size());
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : main_seq
    conv_req_t q;
    // dates: calendar edges, the Julian/Gregorian switch, clamped fields
    req_q.push_back(make_req(CMD_TO_DAYS, 0, 1, 1, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 0, 0, 0, 0));          // month and day zero
    req_q.push_back(make_req(CMD_TO_DAYS, 4, 2, 29, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1582, 10, 4, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1582, 10, 5, 0));      // inside the lost days
    req_q.push_back(make_req(CMD_TO_DAYS, 1582, 10, 14, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1582, 10, 15, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1582, 12, 31, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1583, 1, 1, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 1900, 3, 1, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 2000, 2, 29, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 2023, 2, 31, 0));      // day past month end
    req_q.push_back(make_req(CMD_TO_DAYS, 65535, 12, 31, 0));
    req_q.push_back(make_req(CMD_TO_DAYS, 65535, 15, 31, 33554431)); // month above twelve
    // day numbers: region borders and the top of range
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, 0));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, 59));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, JUL_LAST));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, JUL_LAST + 1));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, GREG_BASE));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, GREG_FIRST));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, 730544));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, LAST_DAY));
    req_q.push_back(make_req(CMD_TO_DATE, 0, 0, 0, LAST_DAY + 1));
    req_q.push_back(make_req(CMD_TO_DATE, 65535, 15, 31, 33554431));
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      q = random_req((i < N_RANDOM / 3) ? 2'd0 : (i < 2 * N_RANDOM / 3) ? 2'd1 : 2'd2);
      // drain the block at every phase change
      q.drain = (i == 0 || i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3);
      req_q.push_back(q);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || n_done < n_sent || conv_exp_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (conv_exp_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, conv_exp_q.size());
      n_err++;
    end

    $display("converted %0d dates and %0d day numbers, %0d flagged out of range",
             n_dates, n_counts, n_oor);
    $display("%0d results checked over three idle patterns, %0d errors", n_done, n_err);
    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
